>>> sv/qre_pkg.sv
// ----------------------------------------------------------------------------
// qre_pkg
// shared widths, types and the arctangent table of the rotation error block
// ----------------------------------------------------------------------------
package qre_pkg;

  localparam int CompW   = 16;  // Q1.15 component
  localparam int ProdW   = 32;  // Q2.30 product
  localparam int DW      = 35;  // conjugate product component
  localparam int MagW    = 33;  // magnitude of a component
  localparam int ScW     = 30;  // scaled magnitude
  localparam int SqW     = 62;  // sum of three squares
  localparam int RootW   = 31;  // floor square root
  localparam int XW      = 36;  // cordic x and y
  localparam int ZW      = 33;  // cordic angle, radians * 2^30
  localparam int AngleW  = 15;
  localparam int AtanLen = 24;

  localparam logic [AngleW-1:0] AngleMax = 15'd25736;

  typedef logic signed [CompW-1:0] comp_t;

  typedef struct packed {
    comp_t w;
    comp_t x;
    comp_t y;
    comp_t z;
  } quat_t;

  // one item walking through the square root cells
  typedef struct packed {
    logic           deg;
    logic [ScW-1:0] m0;
    logic [SqW-1:0] rad;
    logic [SqW-1:0] root;
  } sqrt_data_t;

  // one item walking through the cordic cells
  typedef struct packed {
    logic                 deg;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } cordic_data_t;

  // atan(2^-i) * 2^30
  localparam logic signed [ZW-1:0] AtanTab [AtanLen] = '{
    33'sd843314856, 33'sd497837829, 33'sd263043836, 33'sd133525158,
    33'sd67021686,  33'sd33543515,  33'sd16775850,  33'sd8388437,
    33'sd4194282,   33'sd2097149,   33'sd1048575,   33'sd524287,
    33'sd262143,    33'sd131071,    33'sd65535,     33'sd32767,
    33'sd16383,     33'sd8191,      33'sd4095,      33'sd2047,
    33'sd1023,      33'sd511,       33'sd255,       33'sd127
  };

endpackage

>>> sv/qre_front.sv
// ----------------------------------------------------------------------------
// qre_front
// conjugate product, common scaling and sum of squares, five register stages
// ----------------------------------------------------------------------------
module qre_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                up_vld_i,
  output logic                up_rdy_o,
  input  qre_pkg::quat_t      p_i,
  input  qre_pkg::quat_t      q_i,
  output logic                dn_vld_o,
  input  logic                dn_rdy_i,
  output qre_pkg::sqrt_data_t dn_data_o
);
  import qre_pkg::*;

  localparam int NumSt = 5;

  logic [NumSt-1:0] vld_q;
  logic [NumSt-1:0] en;

  // stage 1: all sixteen component products
  logic signed [ProdW-1:0] pr_q [16];
  // stage 2: conjugate product
  logic signed [DW-1:0]    d_q [4];
  // stage 3: scaled magnitudes
  logic [ScW-1:0]          m_q [4];
  logic                    deg3_q;
  // stage 4: squares of the vector part
  logic [2*ScW-1:0]        sq_q [3];
  logic [ScW-1:0]          m0_4_q;
  logic                    deg4_q;
  // stage 5: radicand
  sqrt_data_t              out_q;

  comp_t                   pc [4];
  comp_t                   qc [4];
  logic [MagW-1:0]         mag [4];
  logic [MagW-1:0]         mag_or;
  logic [1:0]              shamt;

  always_comb begin
    en[NumSt-1] = !vld_q[NumSt-1] || dn_rdy_i;
    for (int k = NumSt - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  assign up_rdy_o  = en[0];
  assign dn_vld_o  = vld_q[NumSt-1];
  assign dn_data_o = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= up_vld_i;
      end
      for (int k = 1; k < NumSt; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  assign pc = '{p_i.w, p_i.x, p_i.y, p_i.z};
  assign qc = '{q_i.w, q_i.x, q_i.y, q_i.z};

  // magnitudes and the shift that brings the largest one below 2^30
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      mag[i] = d_q[i][DW-1] ? MagW'(-d_q[i]) : MagW'(d_q[i]);
    end
    mag_or = mag[0] | mag[1] | mag[2] | mag[3];
    priority if (mag_or[MagW-1]) begin
      shamt = 2'd3;
    end else if (mag_or[MagW-2]) begin
      shamt = 2'd2;
    end else if (mag_or[MagW-3]) begin
      shamt = 2'd1;
    end else begin
      shamt = 2'd0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          pr_q[i*4+j] <= pc[i] * qc[j];
        end
      end
    end
    if (en[1]) begin
      d_q[0] <= DW'(pr_q[0])  + DW'(pr_q[5])  + DW'(pr_q[10]) + DW'(pr_q[15]);
      d_q[1] <= DW'(pr_q[4])  - DW'(pr_q[1])  - DW'(pr_q[11]) + DW'(pr_q[14]);
      d_q[2] <= DW'(pr_q[8])  - DW'(pr_q[2])  - DW'(pr_q[13]) + DW'(pr_q[7]);
      d_q[3] <= DW'(pr_q[12]) - DW'(pr_q[3])  - DW'(pr_q[6])  + DW'(pr_q[9]);
    end
    if (en[2]) begin
      for (int i = 0; i < 4; i++) begin
        m_q[i] <= ScW'(mag[i] >> shamt);
      end
      deg3_q <= (mag_or == '0);
    end
    if (en[3]) begin
      for (int i = 0; i < 3; i++) begin
        sq_q[i] <= (2*ScW)'(m_q[i+1]) * (2*ScW)'(m_q[i+1]);
      end
      m0_4_q <= m_q[0];
      deg4_q <= deg3_q;
    end
    if (en[4]) begin
      out_q.rad  <= SqW'(sq_q[0]) + SqW'(sq_q[1]) + SqW'(sq_q[2]);
      out_q.root <= '0;
      out_q.m0   <= m0_4_q;
      out_q.deg  <= deg4_q;
    end
  end

endmodule

>>> sv/qre_sqrt_cell.sv
// ----------------------------------------------------------------------------
// qre_sqrt_cell
// one result bit of the floor square root, remainder and root held per cell
// ----------------------------------------------------------------------------
module qre_sqrt_cell #(
  parameter int K = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                up_vld_i,
  output logic                up_rdy_o,
  input  qre_pkg::sqrt_data_t up_data_i,
  output logic                dn_vld_o,
  input  logic                dn_rdy_i,
  output qre_pkg::sqrt_data_t dn_data_o
);
  import qre_pkg::*;

  localparam logic [SqW-1:0] Bit = SqW'(1) << (2 * K);

  logic       vld_q;
  logic       en;
  sqrt_data_t data_q;
  sqrt_data_t data_d;
  logic [SqW:0] trial;

  assign en       = !vld_q || dn_rdy_i;
  assign up_rdy_o = en;
  assign dn_vld_o = vld_q;
  assign dn_data_o = data_q;

  always_comb begin
    data_d = up_data_i;
    trial  = {1'b0, up_data_i.root} + {1'b0, Bit};
    if ({1'b0, up_data_i.rad} >= trial) begin
      data_d.rad  = up_data_i.rad - trial[SqW-1:0];
      data_d.root = (up_data_i.root >> 1) + Bit;
    end else begin
      data_d.root = up_data_i.root >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en) begin
      vld_q <= up_vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      data_q <= data_d;
    end
  end

endmodule

>>> sv/qre_cordic_cell.sv
// ----------------------------------------------------------------------------
// qre_cordic_cell
// one vectoring micro-rotation, shift and arctangent fixed per cell
// ----------------------------------------------------------------------------
module qre_cordic_cell #(
  parameter int I = 0
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  up_vld_i,
  output logic                  up_rdy_o,
  input  qre_pkg::cordic_data_t up_data_i,
  output logic                  dn_vld_o,
  input  logic                  dn_rdy_i,
  output qre_pkg::cordic_data_t dn_data_o
);
  import qre_pkg::*;

  localparam logic signed [ZW-1:0] Atan = AtanTab[I];

  logic                 vld_q;
  logic                 en;
  cordic_data_t         data_q;
  cordic_data_t         data_d;
  logic signed [XW-1:0] xs;
  logic signed [XW-1:0] ys;

  assign en        = !vld_q || dn_rdy_i;
  assign up_rdy_o  = en;
  assign dn_vld_o  = vld_q;
  assign dn_data_o = data_q;

  always_comb begin
    // arithmetic shift rounds toward minus infinity
    xs     = up_data_i.x >>> I;
    ys     = up_data_i.y >>> I;
    data_d = up_data_i;
    if (!up_data_i.y[XW-1]) begin
      data_d.x = up_data_i.x + ys;
      data_d.y = up_data_i.y - xs;
      data_d.z = up_data_i.z + Atan;
    end else begin
      data_d.x = up_data_i.x - ys;
      data_d.y = up_data_i.y + xs;
      data_d.z = up_data_i.z - Atan;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en) begin
      vld_q <= up_vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      data_q <= data_d;
    end
  end

endmodule

>>> sv/quaternion_rotation_error.sv
// ----------------------------------------------------------------------------
// quaternion_rotation_error
// geodesic angle between two Q1.15 quaternions, 2*atan2(|vec(d)|, |d0|)
// with d = p * conj(q), result in unsigned Q2.13 radians
// ----------------------------------------------------------------------------
//
// channel  direction  handshake                  payload
// -------  ---------  -------------------------  ---------------------------
// in       input      in_valid_i / in_stall_o    p_w..p_z, q_w..q_z (Q1.15)
// out      output     out_valid_o / out_stall_i  angle (Q2.13), degenerate
//
// one transfer per cycle in and out when the output is not stalled
// the path runs through five front stages, 31 square root
//   cells (one root bit each), one cordic cell per stage, one output register
// every cell keeps its item while the cell after it is full and stalled,
//   so a stalled result holds only the cells up to the first empty one
// in_stall_o is low whenever the output register is empty
// reset clears the valid bits only; the block holds no other state
//
module quaternion_rotation_error #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic signed [15:0]        p_w_i,
  input  logic signed [15:0]        p_x_i,
  input  logic signed [15:0]        p_y_i,
  input  logic signed [15:0]        p_z_i,
  input  logic signed [15:0]        q_w_i,
  input  logic signed [15:0]        q_x_i,
  input  logic signed [15:0]        q_y_i,
  input  logic signed [15:0]        q_z_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [qre_pkg::AngleW-1:0] angle_o,
  output logic                      degenerate_o
);
  import qre_pkg::*;

  // stages past the arctangent table are not run
  localparam int NumCordic = (CORDIC_STAGES > AtanLen) ? AtanLen : CORDIC_STAGES;

  quat_t p;
  quat_t q;
  logic  in_stall_n;

  // square root chain, link 0 is the front output
  logic       sq_vld [RootW+1];
  logic       sq_rdy [RootW+1];
  sqrt_data_t sq_dat [RootW+1];

  // cordic chain, link 0 is the square root output
  logic         co_vld [NumCordic+1];
  logic         co_rdy [NumCordic+1];
  cordic_data_t co_dat [NumCordic+1];

  // output register
  logic              out_vld_q;
  logic              out_en;
  logic [AngleW-1:0] angle_q;
  logic              deg_q;
  logic [AngleW-1:0] angle_d;
  logic [ZW-2:0]     z_pos;
  logic [ZW-1:0]     z_rnd;
  logic [ZW-17:0]    res;

  assign p = '{w: p_w_i, x: p_x_i, y: p_y_i, z: p_z_i};
  assign q = '{w: q_w_i, x: q_x_i, y: q_y_i, z: q_z_i};

  qre_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .up_vld_i  (in_valid_i),
    .up_rdy_o  (in_stall_n),
    .p_i       (p),
    .q_i       (q),
    .dn_vld_o  (sq_vld[0]),
    .dn_rdy_i  (sq_rdy[0]),
    .dn_data_o (sq_dat[0])
  );

  assign in_stall_o = !in_stall_n;

  // root bits from the top down, one cell per bit
  for (genvar g = 0; g < RootW; g++) begin : g_sqrt
    qre_sqrt_cell #(
      .K (RootW - 1 - g)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .up_vld_i  (sq_vld[g]),
      .up_rdy_o  (sq_rdy[g]),
      .up_data_i (sq_dat[g]),
      .dn_vld_o  (sq_vld[g+1]),
      .dn_rdy_i  (sq_rdy[g+1]),
      .dn_data_o (sq_dat[g+1])
    );
  end

  // x is the scaled scalar magnitude, y the vector norm
  assign co_vld[0]     = sq_vld[RootW];
  assign sq_rdy[RootW] = co_rdy[0];
  assign co_dat[0].deg = sq_dat[RootW].deg;
  assign co_dat[0].x   = XW'(sq_dat[RootW].m0);
  assign co_dat[0].y   = XW'(sq_dat[RootW].root[RootW-1:0]);
  assign co_dat[0].z   = '0;

  for (genvar g = 0; g < NumCordic; g++) begin : g_cordic
    qre_cordic_cell #(
      .I (g)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .up_vld_i  (co_vld[g]),
      .up_rdy_o  (co_rdy[g]),
      .up_data_i (co_dat[g]),
      .dn_vld_o  (co_vld[g+1]),
      .dn_rdy_i  (co_rdy[g+1]),
      .dn_data_o (co_dat[g+1])
    );
  end

  // clamp at zero, double and round half up, clamp at pi; zero if degenerate
  always_comb begin
    z_pos = co_dat[NumCordic].z[ZW-1] ? '0 : co_dat[NumCordic].z[ZW-2:0];
    z_rnd = {1'b0, z_pos} + ZW'(32768);
    res   = z_rnd[ZW-1:16];
    if (co_dat[NumCordic].deg) begin
      angle_d = '0;
    end else if (res > (ZW-16)'(AngleMax)) begin
      angle_d = AngleMax;
    end else begin
      angle_d = res[AngleW-1:0];
    end
  end

  assign out_en            = !out_vld_q || !out_stall_i;
  assign co_rdy[NumCordic] = out_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_en) begin
      out_vld_q <= co_vld[NumCordic];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en) begin
      angle_q <= angle_d;
      deg_q   <= co_dat[NumCordic].deg;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign angle_o      = angle_q;
  assign degenerate_o = deg_q;

`ifndef ASSERT_OFF
  a_deg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && degenerate_o |-> angle_o == '0)
    else $error("degenerate result with nonzero angle");

  a_angle_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> angle_o <= AngleMax)
    else $error("angle above pi");

  a_no_stall_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output register");
`endif

endmodule

>>> dv/tb_quaternion_rotation_error.sv
// ----------------------------------------------------------------------------
// tb_quaternion_rotation_error
// checks the geodesic angle between two Q1.15 quaternions, pair by pair,
// against a bit-true predictor or known results, under random idling and stalls
// ----------------------------------------------------------------------------
module tb_quaternion_rotation_error;

  timeunit 1ns;
  timeprecision 1ps;

  import qre_pkg::*;

  // block configuration and timing
  localparam int CordicStages = 16;
  localparam int AtanCount    = 24;
  localparam int Latency      = CordicStages + 37;  // cycles from transfer in to result with no stall
  localparam int NumRandom    = 1000;
  localparam int CycleLimit   = 400000;             // far above the slowest clean run

  localparam comp_t PosMax = 16'sh7fff;
  localparam comp_t NegMax = 16'sh8000;

  // atan(2^-i) scaled by 2^30, our own copy for the predictor
  localparam longint AtanRad [AtanCount] = '{
    843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
    16775850, 8388437, 4194282, 2097149, 1048575, 524287,
    262143, 131071, 65535, 32767, 16383, 8191,
    4095, 2047, 1023, 511, 255, 127
  };

  // one result as the block reports it
  typedef struct packed {
    logic [AngleW-1:0] angle;
    logic              deg;
  } rot_err_t;

  // one row of the directed table; res is used only where known is set
  typedef struct {
    quat_t    p;
    quat_t    q;
    logic     known;
    rot_err_t res;
  } pair_row_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  comp_t             p_w_i = '0;
  comp_t             p_x_i = '0;
  comp_t             p_y_i = '0;
  comp_t             p_z_i = '0;
  comp_t             q_w_i = '0;
  comp_t             q_x_i = '0;
  comp_t             q_y_i = '0;
  comp_t             q_z_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [AngleW-1:0] angle_o;
  logic              degenerate_o;

  rot_err_t pending_angles [$];  // expected results, oldest first
  int       n_errors = 0;
  int       n_cycles = 0;
  rot_err_t oldest_angle;

  quaternion_rotation_error #(
    .CORDIC_STAGES(CordicStages)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .p_w_i       (p_w_i),
    .p_x_i       (p_x_i),
    .p_y_i       (p_y_i),
    .p_z_i       (p_z_i),
    .q_w_i       (q_w_i),
    .q_x_i       (q_x_i),
    .q_y_i       (q_y_i),
    .q_z_i       (q_z_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .angle_o     (angle_o),
    .degenerate_o(degenerate_o)
  );

  always #2 clk_i = ~clk_i;

  // rotation error of one pair: conjugate product, scaled vector norm,
  // then a cordic vectoring pass over (|d0|, norm)
  function automatic rot_err_t predict_rot_err(quat_t p, quat_t q);
    longint            a0, a1, a2, a3, b0, b1, b2, b3;
    longint            d0, d1, d2, d3;
    longint            x, y, z, xs, ys;
    longint unsigned   m0, m1, m2, m3, mx, rad, root, probe, rounded;
    int                sh;
    rot_err_t          r;
    a0 = p.w; a1 = p.x; a2 = p.y; a3 = p.z;
    b0 = q.w; b1 = q.x; b2 = q.y; b3 = q.z;
    d0 =  a0 * b0 + a1 * b1 + a2 * b2 + a3 * b3;
    d1 = -a0 * b1 + a1 * b0 - a2 * b3 + a3 * b2;
    d2 = -a0 * b2 + a2 * b0 - a3 * b1 + a1 * b3;
    d3 = -a0 * b3 + a3 * b0 - a1 * b2 + a2 * b1;
    // a zero product has no direction: flag it, angle forced to zero
    if (d0 == 0 && d1 == 0 && d2 == 0 && d3 == 0) begin
      r.angle = '0;
      r.deg   = 1'b1;
      return r;
    end
    m0 = (d0 < 0) ? -d0 : d0;
    m1 = (d1 < 0) ? -d1 : d1;
    m2 = (d2 < 0) ? -d2 : d2;
    m3 = (d3 < 0) ? -d3 : d3;
    mx = m0;
    if (m1 > mx) mx = m1;
    if (m2 > mx) mx = m2;
    if (m3 > mx) mx = m3;
    // common truncating shift that brings every magnitude below 2^30
    sh = 0;
    while ((mx >> sh) >= (64'd1 << 30)) sh++;
    m0 = m0 >> sh;
    m1 = m1 >> sh;
    m2 = m2 >> sh;
    m3 = m3 >> sh;
    // floor square root, two bits of radicand per step
    rad   = m1 * m1 + m2 * m2 + m3 * m3;
    root  = 0;
    probe = 64'd1 << 62;
    while (probe > rad) probe = probe >> 2;
    while (probe != 0) begin
      if (rad >= root + probe) begin
        rad  = rad - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    // vectoring: drive y to zero, z collects the angle; >>> floors negatives
    x = longint'(m0);
    y = longint'(root);
    z = 0;
    for (int i = 0; i < CordicStages && i < AtanCount; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + AtanRad[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - AtanRad[i];
      end
    end
    if (z < 0) z = 0;
    // doubled angle in Q2.13, rounded half up, clamped at pi
    rounded = (unsigned'(z) + 64'd32768) >> 16;
    if (rounded > AngleMax) rounded = 64'(AngleMax);
    r.angle = rounded[AngleW-1:0];
    r.deg   = 1'b0;
    return r;
  endfunction

  // component near c, saturated to Q1.15
  function automatic comp_t comp_near(int c, int spread);
    int v;
    v = c + int'($urandom_range(0, 2 * spread)) - spread;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return comp_t'(v);
  endfunction

  // one of the corner values of a component
  function automatic comp_t comp_corner();
    case ($urandom_range(0, 4))
      0:       return NegMax;
      1:       return PosMax;
      2:       return 16'sd0;
      3:       return -16'sd1;
      default: return 16'sd1;
    endcase
  endfunction

  // directed pairs: zero products, extreme products, pure vector products,
  // smallest nonzero products, negative scalar part, alternating bit patterns
  pair_row_t dir_rows [18] = '{
    '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0}, '{16'sd0, 16'sd0, 16'sd0, 16'sd0},
      1'b1, '{15'd0, 1'b1}},
    '{'{PosMax, PosMax, PosMax, PosMax}, '{16'sd0, 16'sd0, 16'sd0, 16'sd0},
      1'b1, '{15'd0, 1'b1}},
    '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0}, '{NegMax, NegMax, NegMax, NegMax},
      1'b1, '{15'd0, 1'b1}},
    '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0}, '{16'sd1, 16'sd0, 16'sd0, 16'sd0},
      1'b1, '{15'd0, 1'b1}},
    '{'{PosMax, 16'sd0, 16'sd0, 16'sd0}, '{PosMax, 16'sd0, 16'sd0, 16'sd0},
      1'b0, '{15'd0, 1'b0}},
    '{'{NegMax, NegMax, NegMax, NegMax}, '{NegMax, NegMax, NegMax, NegMax},
      1'b0, '{15'd0, 1'b0}},
    '{'{NegMax, NegMax, NegMax, NegMax}, '{PosMax, PosMax, PosMax, PosMax},
      1'b0, '{15'd0, 1'b0}},
    '{'{PosMax, 16'sd0, 16'sd0, 16'sd0}, '{16'sd0, PosMax, 16'sd0, 16'sd0},
      1'b0, '{15'd0, 1'b0}},
    '{'{16'sd0, NegMax, 16'sd0, 16'sd0}, '{NegMax, 16'sd0, 16'sd0, 16'sd0},
      1'b0, '{15'd0, 1'b0}},
    '{'{16'sd0, 16'sd0, PosMax, 16'sd0}, '{16'sd0, 16'sd0, 16'sd0, NegMax},
      1'b0, '{15'd0, 1'b0}},
    '{'{16'sd1, 16'sd0, 16'sd0, 16'sd0}, '{16'sd1, 16'sd0, 16'sd0, 16'sd0},
      1'b0, '{15'd0, 1'b0}},
    '{'{16'sd1, 16'sd0, 16'sd0, 16'sd0}, '{16'sd0, 16'sd0, 16'sd0, 16'sd1},
      1'b0, '{15'd0, 1'b0}},
    '{'{-16'sd1, -16'sd1, -16'sd1, -16'sd1}, '{16'sd1, 16'sd1, 16'sd1, 16'sd1},
      1'b0, '{15'd0, 1'b0}},
    '{'{16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa},
      '{16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555}, 1'b0, '{15'd0, 1'b0}},
    '{'{PosMax, NegMax, PosMax, NegMax}, '{NegMax, PosMax, NegMax, PosMax},
      1'b0, '{15'd0, 1'b0}},
    '{'{PosMax, PosMax, 16'sd0, 16'sd0}, '{PosMax, 16'sd0, 16'sd0, 16'sd0},
      1'b0, '{15'd0, 1'b0}},
    '{'{16'sd23170, 16'sd0, 16'sd0, 16'sd23170}, '{PosMax, 16'sd0, 16'sd0, 16'sd0},
      1'b0, '{15'd0, 1'b0}},
    '{'{NegMax, 16'sd0, 16'sd0, 16'sd0}, '{PosMax, PosMax, PosMax, PosMax},
      1'b0, '{15'd0, 1'b0}}
  };

  // drive one pair from a falling edge, hold it until the transfer, then
  // queue what it must produce; returns on the next falling edge
  task automatic send_pair(quat_t p, quat_t q, logic known, rot_err_t typed);
    in_valid_i <= 1'b1;
    p_w_i <= p.w;
    p_x_i <= p.x;
    p_y_i <= p.y;
    p_z_i <= p.z;
    q_w_i <= q.w;
    q_x_i <= q.x;
    q_y_i <= q.y;
    q_z_i <= q.z;
    do @(posedge clk_i); while (in_stall_o);
    pending_angles.push_back(known ? typed : predict_rot_err(p, q));
    @(negedge clk_i);
  endtask

  // sender stops and waits out every result in flight
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_angles.size() != 0) @(negedge clk_i);
  endtask

  // stimulus: reset, directed table, then random pairs in bursts
  initial begin
    quat_t p, q;
    int    burst_left;
    int    gap;
    rot_err_t none;
    none = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) send_pair(dir_rows[i].p, dir_rows[i].q, dir_rows[i].known,
                                    dir_rows[i].res);
    // the pipeline runs empty once before random traffic starts
    drain_results();

    burst_left = 0;
    for (int n = 0; n < NumRandom; n++) begin
      if (n == NumRandom / 2) drain_results();
      // between bursts the sender may go quiet for a random while
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        if (gap > 0) begin
          in_valid_i <= 1'b0;
          repeat (gap) @(negedge clk_i);
        end
      end
      burst_left--;

      p = {comp_t'($urandom()), comp_t'($urandom()), comp_t'($urandom()),
           comp_t'($urandom())};
      q = {comp_t'($urandom()), comp_t'($urandom()), comp_t'($urandom()),
           comp_t'($urandom())};
      case ($urandom_range(0, 9))
        4, 5: begin
          // nearly the same orientation: small angles
          q = {comp_near(p.w, 64), comp_near(p.x, 64), comp_near(p.y, 64),
               comp_near(p.z, 64)};
        end
        6: begin
          // nearly the opposite sign: also small angles, d0 negative
          q = {comp_near(-int'(p.w), 300), comp_near(-int'(p.x), 300),
               comp_near(-int'(p.y), 300), comp_near(-int'(p.z), 300)};
        end
        7: begin
          // tiny components, products near the bottom of the range
          p = {comp_near(0, 4), comp_near(0, 4), comp_near(0, 4), comp_near(0, 4)};
          q = {comp_near(0, 4), comp_near(0, 4), comp_near(0, 4), comp_near(0, 4)};
        end
        8: begin
          p = {comp_corner(), comp_corner(), comp_corner(), comp_corner()};
          q = {comp_corner(), comp_corner(), comp_corner(), comp_corner()};
        end
        9: begin
          // a zero quaternion on one side or both gives a zero product
          case ($urandom_range(0, 2))
            0:       p = '0;
            1:       q = '0;
            default: begin
              p = '0;
              q = '0;
            end
          endcase
        end
        default: ;  // full-range random pair
      endcase
      send_pair(p, q, 1'b0, none);
    end

    drain_results();
    repeat (Latency + 8) @(posedge clk_i);
    if (pending_angles.size() != 0) begin
      $error("%0d results never arrived", pending_angles.size());
      n_errors++;
    end
    if (n_errors == 0) begin
      $display("tb_quaternion_rotation_error: done, clean");
    end else begin
      $display("tb_quaternion_rotation_error: done, errors");
    end
    $finish;
  end

  // receiver stall: stretches of free flow, random stall, heavy stall and
  // a fixed one-in-three pattern, each of random length
  initial begin
    int mode;
    int span;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(5, 60);
      for (int k = 0; k < span; k++) begin
        @(negedge clk_i);
        case (mode)
          0:       out_stall_i <= 1'b0;
          1:       out_stall_i <= 1'($urandom_range(0, 1));
          2:       out_stall_i <= ($urandom_range(0, 3) != 0);
          default: out_stall_i <= (k % 3 == 0);
        endcase
      end
    end
  end

  // every result transfer is matched against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_angles.size() == 0) begin
        $error("result with nothing expected: angle %0d degenerate %0b",
               angle_o, degenerate_o);
        n_errors++;
      end else begin
        oldest_angle = pending_angles.pop_front();
        if (angle_o !== oldest_angle.angle) begin
          $error("angle: expected %0d, got %0d", oldest_angle.angle, angle_o);
          n_errors++;
        end
        if (degenerate_o !== oldest_angle.deg) begin
          $error("degenerate: expected %0b, got %0b", oldest_angle.deg, degenerate_o);
          n_errors++;
        end
      end
    end
  end

  // hard stop if the run hangs
  always @(posedge clk_i) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles == CycleLimit) begin
      $display("tb_quaternion_rotation_error: done, errors");
      $finish;
    end
  end

endmodule

>>> sim.f
sv/qre_pkg.sv
sv/qre_front.sv
sv/qre_sqrt_cell.sv
sv/qre_cordic_cell.sv
sv/quaternion_rotation_error.sv
dv/tb_quaternion_rotation_error.sv
